[hw/rtl/cookie_date_parser_core_defines.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef COOKIE_DATE_PARSER_CORE_DEFINES_SVH
`define COOKIE_DATE_PARSER_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define CDP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define CDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hw/rtl/cdp_pkg.sv]
// Package for the cookie date parser: types, constants and helper functions.
// No dependencies.
`timescale 1ns / 1ps
package cdp_pkg;

  localparam int unsigned SecW = 39;
  localparam int unsigned QDepth = 2;

  // Fields collected for one finished string, handed from front to back.
  typedef struct packed {
    logic [3:0]  found;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } fields_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DAYS, BK_MUL1, BK_MUL2, BK_SUM, BK_OUT
  } back_state_t;

  function automatic logic is_delim(input logic [7:0] c);
    is_delim = (c == 8'h09) || (c >= 8'h20 && c <= 8'h2f) || (c >= 8'h3b && c <= 8'h40)
            || (c >= 8'h5b && c <= 8'h60) || (c >= 8'h7b && c <= 8'h7e);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  // Month number 1..12 for a three letter name, zero for no match.
  function automatic logic [3:0] month_code(input logic [23:0] s);
    case (s)
      "jan": month_code = 4'd1;
      "feb": month_code = 4'd2;
      "mar": month_code = 4'd3;
      "apr": month_code = 4'd4;
      "may": month_code = 4'd5;
      "jun": month_code = 4'd6;
      "jul": month_code = 4'd7;
      "aug": month_code = 4'd8;
      "sep": month_code = 4'd9;
      "oct": month_code = 4'd10;
      "nov": month_code = 4'd11;
      "dec": month_code = 4'd12;
      default: month_code = 4'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd2: month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

  // Days before month m (March based), i.e. (153*(mm-3)+2)/5 for mm 3..14.
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    case (m)
      4'd3: month_offset = 9'd0;
      4'd4: month_offset = 9'd31;
      4'd5: month_offset = 9'd61;
      4'd6: month_offset = 9'd92;
      4'd7: month_offset = 9'd122;
      4'd8: month_offset = 9'd153;
      4'd9: month_offset = 9'd184;
      4'd10: month_offset = 9'd214;
      4'd11: month_offset = 9'd245;
      4'd12: month_offset = 9'd275;
      4'd1: month_offset = 9'd306;
      4'd2: month_offset = 9'd337;
      default: month_offset = 9'd0;
    endcase
  endfunction

endpackage

[hw/rtl/cdp_front.sv]
// Front end: tokenizes bytes and collects date fields, one byte per cycle while the queue has room.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
module cdp_front import cdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       in_ready,
  output logic       push,
  output fields_t    push_fields,
  input  logic       q_full
);

  fields_t     fld;
  logic [2:0]  tlen;
  logic        tdig;
  logic [13:0] tnum;
  logic [6:0]  tp0, tp1, tp2;
  logic [2:0]  tcnt;
  logic [1:0]  rlen;
  logic [6:0]  rval;
  logic        tok;
  logic [7:0]  lb0, lb1, lb2;

  // token state after this byte (take_char applied if not delimiter)
  logic [2:0]  n_tlen;
  logic        n_tdig;
  logic [13:0] n_tnum;
  logic [6:0]  n_tp0, n_tp1, n_tp2;
  logic [2:0]  n_tcnt;
  logic [1:0]  n_rlen;
  logic [6:0]  n_rval;
  logic        n_tok;
  logic [7:0]  n_lb0, n_lb1, n_lb2;
  fields_t     f1, f2;
  logic        dl, dg;
  logic [3:0]  dv;

  assign in_ready = !q_full;
  wire acc = in_valid && in_ready;

  // closes the current colon run
  function automatic void end_run_f(
    inout logic [2:0] c, inout logic [1:0] rl, inout logic [6:0] rv, inout logic ok,
    inout logic [6:0] p0, inout logic [6:0] p1, inout logic [6:0] p2);
    if (rl != 2'd0) begin
      if (rl > 2'd2) ok = 1'b0;
      if (c == 3'd0) p0 = rv;
      if (c == 3'd1) p1 = rv;
      if (c == 3'd2) p2 = rv;
      if (c < 3'd4) c = c + 3'd1;
    end
    rl = 2'd0;
    rv = 7'd0;
  endfunction

  // end of token: returns updated fields
  function automatic fields_t end_tok(
    input fields_t f, input logic [2:0] l, input logic dgt, input logic [13:0] num,
    input logic [6:0] p0i, input logic [6:0] p1i, input logic [6:0] p2i,
    input logic [2:0] ci, input logic [1:0] rli, input logic [6:0] rvi, input logic oki,
    input logic [7:0] a, input logic [7:0] b, input logic [7:0] d);
    fields_t r;
    logic [2:0] c;
    logic [1:0] rl;
    logic [6:0] rv, p0, p1, p2;
    logic ok;
    logic [3:0] mon;
    r = f; c = ci; rl = rli; rv = rvi; ok = oki; p0 = p0i; p1 = p1i; p2 = p2i;
    if (l != 3'd0) begin
      end_run_f(c, rl, rv, ok, p0, p1, p2);
      mon = (l == 3'd3) ? month_code({to_lower(a), to_lower(b), to_lower(d)}) : 4'd0;
      if (!f.found[0] && ok && c == 3'd3) begin
        r.found[0] = 1'b1; r.hour = p0; r.minute = p1; r.second = p2;
      end else if (!f.found[1] && dgt && l <= 3'd2) begin
        r.found[1] = 1'b1; r.day = num[6:0];
      end else if (!f.found[2] && mon != 4'd0) begin
        r.found[2] = 1'b1; r.month = mon;
      end else if (!f.found[3] && dgt && (l == 3'd2 || l == 3'd4)) begin
        r.found[3] = 1'b1; r.year = num;
      end
    end
    return r;
  endfunction

  always_comb begin
    dl = is_delim(in_byte);
    dg = in_byte >= 8'h30 && in_byte <= 8'h39;
    dv = in_byte[3:0];
    n_tlen = tlen; n_tdig = tdig; n_tnum = tnum; n_tp0 = tp0; n_tp1 = tp1; n_tp2 = tp2;
    n_tcnt = tcnt; n_rlen = rlen; n_rval = rval; n_tok = tok;
    n_lb0 = lb0; n_lb1 = lb1; n_lb2 = lb2;
    f1 = fld;
    if (dl) begin
      f1 = end_tok(fld, tlen, tdig, tnum, tp0, tp1, tp2, tcnt, rlen, rval, tok,
                   lb0, lb1, lb2);
      if (tlen != 3'd0) begin
        n_tlen = 3'd0; n_tdig = 1'b1; n_tnum = 14'd0; n_tp0 = 7'd0; n_tp1 = 7'd0;
        n_tp2 = 7'd0; n_tcnt = 3'd0; n_rlen = 2'd0; n_rval = 7'd0; n_tok = 1'b1;
        n_lb0 = 8'd0; n_lb1 = 8'd0; n_lb2 = 8'd0;
      end
    end else begin
      if (tlen == 3'd0) n_lb0 = in_byte;
      if (tlen == 3'd1) n_lb1 = in_byte;
      if (tlen == 3'd2) n_lb2 = in_byte;
      if (!dg) n_tdig = 1'b0;
      else if (tlen < 3'd4) n_tnum = 14'(tnum * 14'd10 + 14'(dv));
      if (in_byte == 8'h3a) begin
        end_run_f(n_tcnt, n_rlen, n_rval, n_tok, n_tp0, n_tp1, n_tp2);
      end else if (dg) begin
        if (rlen < 2'd2) n_rval = 7'(rval * 7'd10 + 7'(dv));
        if (rlen < 2'd3) n_rlen = rlen + 2'd1;
      end else begin
        n_tok = 1'b0;
      end
      if (tlen < 3'd5) n_tlen = tlen + 3'd1;
    end
    f2 = end_tok(f1, n_tlen, n_tdig, n_tnum, n_tp0, n_tp1, n_tp2, n_tcnt, n_rlen,
                 n_rval, n_tok, n_lb0, n_lb1, n_lb2);
  end

  assign push = acc && in_last;
  assign push_fields = f2;

  always_ff @(posedge clk) begin
    if (rst || (acc && in_last)) begin
      fld <= '0;
      tlen <= 3'd0; tdig <= 1'b1; tnum <= 14'd0; tp0 <= 7'd0; tp1 <= 7'd0; tp2 <= 7'd0;
      tcnt <= 3'd0; rlen <= 2'd0; rval <= 7'd0; tok <= 1'b1;
      lb0 <= 8'd0; lb1 <= 8'd0; lb2 <= 8'd0;
    end else if (acc) begin
      fld <= f1;
      tlen <= n_tlen; tdig <= n_tdig; tnum <= n_tnum; tp0 <= n_tp0; tp1 <= n_tp1;
      tp2 <= n_tp2; tcnt <= n_tcnt; rlen <= n_rlen; rval <= n_rval; tok <= n_tok;
      lb0 <= n_lb0; lb1 <= n_lb1; lb2 <= n_lb2;
    end
  end

endmodule

[hw/rtl/cdp_queue.sv]
// Small FIFO of collected field sets between front and back.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
module cdp_queue import cdp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  fields_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output fields_t pop_data
);

  localparam int unsigned PtrW = $clog2(QDepth);
  fields_t mem [QDepth];
  logic [PtrW-1:0] wp, rp;
  logic [PtrW:0] cnt;

  assign full = cnt == (PtrW+1)'(QDepth);
  assign not_empty = cnt != '0;
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

[hw/rtl/cdp_back.sv]
// Back end: validates a field set and converts it to Unix seconds.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
module cdp_back import cdp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  fields_t           q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_date_ok,
  output logic [SecW-1:0]   out_secs
);

  back_state_t st, st_next;
  fields_t f;
  logic [13:0] y;
  logic        ok;
  logic [21:0] days;     // civil days counted from year 0 March 1
  logic [38:0] dsec;
  logic [16:0] tsec;
  logic [13:0] yy, yq4, yq100, yq400;
  logic [13:0] yf;
  logic        leap;
  logic [26:0] prod;
  logic [13:0] c100;     // y / 100
  logic [13:0] r100;     // y % 100

  always_comb begin
    yf = q_data.year;
    if (q_data.year >= 14'd70 && q_data.year <= 14'd99) yf = q_data.year + 14'd1900;
    else if (q_data.year <= 14'd69) yf = q_data.year + 14'd2000;
  end

  // y / 100 by reciprocal multiply (5243 / 2^19), exact for all 14-bit y.
  // Quotients for yy = y - 1 follow from those of y: floor((y-1)/100) drops
  // by one only when y is a multiple of 100, and yy/400 = (yy/100)/4.
  always_comb begin
    prod = 27'(y) * 27'd5243;
    r100 = y - 14'(c100 * 14'd100);
    leap = (y[1:0] == 2'b00) && (r100 != 14'd0 || c100[1:0] == 2'b00);
    yy = (f.month <= 4'd2) ? y - 14'd1 : y;
    yq4 = yy >> 2;
    yq100 = (f.month <= 4'd2 && r100 == 14'd0) ? c100 - 14'd1 : c100;
    yq400 = yq100 >> 2;
  end

  always_comb begin
    st_next = st;
    q_pop = 1'b0;
    out_valid = 1'b0;
    case (st)
      BK_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        st_next = BK_DAYS;
      end
      BK_DAYS: st_next = BK_MUL1;
      BK_MUL1: st_next = BK_MUL2;
      BK_MUL2: st_next = BK_SUM;
      BK_SUM:  st_next = BK_OUT;
      BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready) st_next = BK_IDLE;
      end
      default: st_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= BK_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    case (st)
      BK_IDLE: if (q_valid) begin
        f <= q_data;
        y <= yf;
        ok <= q_data.found == 4'hf && q_data.day >= 7'd1 && q_data.day <= 7'd31
           && yf >= 14'd1601 && q_data.hour <= 7'd23 && q_data.minute <= 7'd59
           && q_data.second <= 7'd59 && q_data.month >= 4'd1 && q_data.month <= 4'd12;
      end
      BK_DAYS: begin
        c100 <= 14'(prod[26:19]);
        tsec <= 17'(f.hour) * 17'd3600 + 17'(f.minute) * 17'd60;
      end
      BK_MUL1: begin
        if (5'(f.day) > month_len(f.month, leap)) ok <= 1'b0;
        days <= 22'(yy) * 22'd365 + 22'(yq4) - 22'(yq100) + 22'(yq400)
              + 22'(month_offset(f.month)) + 22'(f.day) - 22'd1;
      end
      // epoch offset folded in: 719468 days * 86400
      BK_MUL2: dsec <= 39'(days) * 39'd86400 - 39'd62162035200;
      BK_SUM: begin
        out_date_ok <= ok;
        out_secs <= ok ? dsec + 39'(tsec) + 39'(f.second) : '0;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/cookie_date_parser_core.sv]
// Cookie date parser top level: front tokenizer, field queue, conversion back end.
// Depends on cdp_pkg, cdp_front, cdp_queue, cdp_back.
// Throughput: one byte per cycle while the queue has room; the back end converts one string at a time.
// m_tvalid rises after the final byte once the back end has done its range check, century
// quotient, day count, multiply and sum steps, later when the queue holds earlier strings.
// Reset: synchronous rst clears token state and the queue and returns the back end to idle.
`timescale 1ns / 1ps
module cookie_date_parser_core import cdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [0] date_valid, [39:1] unix_seconds
);

  logic    push, full, pop, nempty;
  fields_t pf, qf;
  logic    ok;
  logic [SecW-1:0] secs;

  cdp_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_byte(s_tdata), .in_last(s_tlast),
    .in_ready(s_tready), .push, .push_fields(pf), .q_full(full)
  );

  cdp_queue u_queue (
    .clk, .rst, .push, .push_data(pf), .full, .pop, .not_empty(nempty), .pop_data(qf)
  );

  cdp_back u_back (
    .clk, .rst, .q_valid(nempty), .q_data(qf), .q_pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_date_ok(ok), .out_secs(secs)
  );

  assign m_tdata = {secs, ok};

endmodule

[hw/rtl/cookie_date_parser_core_checker.sv]
// Port-level checker for the cookie date parser, bound to the top level.
// Depends on cookie_date_parser_core_defines.svh.
`timescale 1ns / 1ps
`include "cookie_date_parser_core_defines.svh"
module cookie_date_parser_core_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  `CDP_ASSERT_IMPL(a_zero_if_invalid, clk, rst, m_tvalid && !m_tdata[0], m_tdata[39:1] == 39'd0, "seconds nonzero on invalid date")
  `CDP_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
  `CDP_ASSERT_NEXT(a_no_early, clk, rst, s_tvalid && s_tready && s_tlast, !m_tvalid || $past(m_tvalid), "result appeared too early")
endmodule

bind cookie_date_parser_core cookie_date_parser_core_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .s_tlast, .m_tvalid, .m_tready, .m_tdata
);
